[rtl/sac_pkg.sv]
package sac_pkg;

	// Item kinds
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_BLEND = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd0;
	localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd1;
	localparam logic [2:0] REG_DEST_X        = 3'd2;
	localparam logic [2:0] REG_DEST_Y        = 3'd3;
	localparam logic [2:0] REG_FRAME_WIDTH   = 3'd4;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd5;

	localparam logic [7:0] FULL_ALPHA = 8'd255;
	localparam logic [7:0] HIT_FLOOR  = 8'd16;

	// Row times width, 9 by 9 bits
	localparam int PROD_W = 18;

	// Canvas word layout, blue in the low byte
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

endpackage

[rtl/sprite_alpha_compositor_core.sv]
// Sprite compositor over a BGRA canvas held in one single-port synchronous RAM of
// MAX_WIDTH*MAX_HEIGHT words. Items are handled one at a time and in_stall stays high
// until the current one is done: a blend passes capture, row multiply, RAM read,
// premultiply and write back; a read passes capture, row multiply and RAM read, then
// waits for the previous result word to be taken; a clear writes W*H words, one RAM
// word per cycle, with W and H the canvas size in use. No two items touch the RAM
// at once, so no forwarding is needed. Only read items give a result word. Canvas
// contents are undefined after reset until cleared or blended.
module sprite_alpha_compositor_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [10:0] pos_x,
	input  logic [10:0] pos_y,
	input  logic [7:0]  src_red,
	input  logic [7:0]  src_green,
	input  logic [7:0]  src_blue,
	input  logic [7:0]  src_alpha,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	output logic [7:0]  out_alpha,
	output logic        inside_res,
	output logic        hit
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_MIX  = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_CLR  = 3'd5;

	logic [2:0] state_q;

	logic [8:0] canvas_width_q, canvas_height_q, frame_width_q, frame_height_q;
	logic [9:0] dest_x_q, dest_y_q;

	logic [1:0]      kind_q;
	logic            act_q;
	logic [8:0]      col_q, row_q;
	sac_pkg::pixel_t src_q;
	logic [sac_pkg::PROD_W-1:0] prod_q;
	logic [AW-1:0]   addr_q;
	logic [CW-1:0]   clr_idx_q;

	logic [8:0]  eff_w, eff_h, mul_b;
	logic [11:0] cx, cy;
	logic        frame_ok, blend_on, read_on, accept, out_load;
	logic [sac_pkg::PROD_W:0] addr_sum;
	logic [AW-1:0]   ram_addr;
	logic            ram_re, ram_we;
	sac_pkg::pixel_t ram_wdata, ram_rdata, blend_res, rd_word, in_pix;

	// Canvas size in use, capped at the store's size
	assign eff_w = (32'(canvas_width_q) < MAX_WIDTH) ? canvas_width_q : 9'(MAX_WIDTH);
	assign eff_h = (32'(canvas_height_q) < MAX_HEIGHT) ? canvas_height_q : 9'(MAX_HEIGHT);

	// Clipping of the incoming item
	assign cx = {pos_x[10], pos_x} + {{2{dest_x_q[9]}}, dest_x_q};
	assign cy = {pos_y[10], pos_y} + {{2{dest_y_q[9]}}, dest_y_q};
	assign frame_ok = !pos_x[10] && !pos_y[10]
		&& (pos_x[9:0] < {1'b0, frame_width_q}) && (pos_y[9:0] < {1'b0, frame_height_q});
	assign blend_on = frame_ok && !cx[11] && !cy[11]
		&& (cx[10:0] < {2'b00, eff_w}) && (cy[10:0] < {2'b00, eff_h})
		&& (src_alpha != 8'd0);
	assign read_on = !pos_x[10] && !pos_y[10]
		&& (pos_x[9:0] < {1'b0, eff_w}) && (pos_y[9:0] < {1'b0, eff_h});

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign in_pix.alpha = src_alpha;
	assign in_pix.red   = src_red;
	assign in_pix.green = src_green;
	assign in_pix.blue  = src_blue;

	// Shared multiplier: row * width for an address, height * width for a clear
	assign mul_b    = (kind_q == sac_pkg::KIND_CLEAR) ? eff_h : row_q;
	assign addr_sum = {1'b0, prod_q} + {{(sac_pkg::PROD_W - 8){1'b0}}, col_q};

	assign out_load = (state_q == S_MIX) && (kind_q == sac_pkg::KIND_READ)
		&& (!out_valid || !out_stall);

	// RAM port
	always_comb begin
		ram_re    = (state_q == S_RD) && act_q && (kind_q != sac_pkg::KIND_CLEAR);
		ram_we    = (state_q == S_WR) || (state_q == S_CLR);
		ram_wdata = (state_q == S_WR) ? blend_res : '0;
		unique case (state_q)
			S_CLR:   ram_addr = clr_idx_q[AW-1:0];
			S_WR:    ram_addr = addr_q;
			default: ram_addr = AW'(addr_sum);
		endcase
	end

	sac_canvas_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.re    (ram_re),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	sac_blend u_blend (
		.clk  (clk),
		.load ((state_q == S_MIX) && (kind_q == sac_pkg::KIND_BLEND)),
		.src  (src_q),
		.dst  (ram_rdata),
		.res  (blend_res)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= 9'd256;
			canvas_height_q <= 9'd256;
			dest_x_q        <= '0;
			dest_y_q        <= '0;
			frame_width_q   <= '0;
			frame_height_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sac_pkg::REG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data[8:0];
				sac_pkg::REG_CANVAS_HEIGHT: canvas_height_q <= cfg_data[8:0];
				sac_pkg::REG_DEST_X:        dest_x_q        <= cfg_data;
				sac_pkg::REG_DEST_Y:        dest_y_q        <= cfg_data;
				sac_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg_data[8:0];
				sac_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			act_q  <= (kind == sac_pkg::KIND_BLEND) ? blend_on : read_on;
			col_q  <= (kind == sac_pkg::KIND_BLEND) ? cx[8:0] : pos_x[8:0];
			row_q  <= (kind == sac_pkg::KIND_BLEND) ? cy[8:0] : pos_y[8:0];
			src_q  <= in_pix;
		end
		if (state_q == S_MUL) begin
			prod_q <= sac_pkg::PROD_W'(mul_b * eff_w);
		end
		if (state_q == S_RD) begin
			addr_q <= AW'(addr_sum);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			clr_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == sac_pkg::KIND_CLEAR || kind == sac_pkg::KIND_READ
							|| (kind == sac_pkg::KIND_BLEND && blend_on)) begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: state_q <= S_RD;
				S_RD: begin
					if (kind_q == sac_pkg::KIND_CLEAR) begin
						state_q <= (prod_q == '0) ? S_IDLE : S_CLR;
					end else begin
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					if (kind_q == sac_pkg::KIND_BLEND) begin
						state_q <= S_WR;
					end else if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				S_WR: state_q <= S_IDLE;
				S_CLR: begin
					if (32'(clr_idx_q) + 1 == 32'(prod_q)) begin
						clr_idx_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result word register
	assign rd_word = act_q ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_blue   <= rd_word.blue;
			out_green  <= rd_word.green;
			out_red    <= rd_word.red;
			out_alpha  <= rd_word.alpha;
			inside_res <= act_q;
			hit        <= act_q && (rd_word.alpha > sac_pkg::HIT_FLOOR);
		end
	end

	// Checks
	a_clr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> (32'(clr_idx_q) < 32'(prod_q)))
		else $error("clear walk beyond canvas");

	a_hit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (inside_res && out_alpha > sac_pkg::HIT_FLOOR))
		else $error("hit without an inside, opaque pixel");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_re && ram_we))
		else $error("RAM read and write in one cycle");

	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && state_q == S_IDLE))
		else $error("read result not presented");

endmodule

[rtl/sac_canvas_ram.sv]
module sac_canvas_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                 clk,
	input  logic                 re,
	input  logic                 we,
	input  logic [AW-1:0]        addr,
	input  sac_pkg::pixel_t      wdata,
	output sac_pkg::pixel_t      rdata
);

	sac_pkg::pixel_t mem [DEPTH];

	// Single port, write wins, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

[rtl/sac_blend.sv]
module sac_blend (
	input  logic            clk,
	input  logic            load,
	input  sac_pkg::pixel_t src,
	input  sac_pkg::pixel_t dst,
	output sac_pkg::pixel_t res
);

	logic [15:0] sr_s1, sg_s1, sb_s1;
	logic [15:0] dr_s1, dg_s1, db_s1, da_s1;
	logic [7:0]  a_s1;
	logic [7:0]  inv_a;
	logic [8:0]  sum_r, sum_g, sum_b, sum_a;

	// x / 255 truncating, exact for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	assign inv_a = sac_pkg::FULL_ALPHA - src.alpha;

	// Stage 1: premultiply source, weight destination
	always_ff @(posedge clk) begin
		if (load) begin
			sr_s1 <= src.red * src.alpha;
			sg_s1 <= src.green * src.alpha;
			sb_s1 <= src.blue * src.alpha;
			dr_s1 <= dst.red * inv_a;
			dg_s1 <= dst.green * inv_a;
			db_s1 <= dst.blue * inv_a;
			da_s1 <= dst.alpha * inv_a;
			a_s1  <= src.alpha;
		end
	end

	// Stage 2: scale back and add, each term truncated on its own
	always_comb begin
		sum_r = {1'b0, div255(sr_s1)} + {1'b0, div255(dr_s1)};
		sum_g = {1'b0, div255(sg_s1)} + {1'b0, div255(dg_s1)};
		sum_b = {1'b0, div255(sb_s1)} + {1'b0, div255(db_s1)};
		sum_a = {1'b0, a_s1} + {1'b0, div255(da_s1)};
		res.red   = sum_r[7:0];
		res.green = sum_g[7:0];
		res.blue  = sum_b[7:0];
		res.alpha = sum_a[7:0];
	end

endmodule

[tb/sv/sprite_alpha_compositor_core_tb.sv]
`timescale 1ns / 100ps

module sprite_alpha_compositor_core_tb;

	localparam int MAX_W     = 256;
	localparam int MAX_H     = 256;
	localparam int RUN_LIMIT = 1000000;

	// kind 3 has no meaning in the block and must be ignored
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         op;
		logic signed [10:0] x;
		logic signed [10:0] y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
	} sprite_word_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic       in_canvas;
		logic       hit;
	} read_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = sac_pkg::REG_CANVAS_WIDTH;
	logic [9:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = sac_pkg::KIND_CLEAR;
	logic [10:0] pos_x = '0;
	logic [10:0] pos_y = '0;
	logic [7:0]  src_red = '0;
	logic [7:0]  src_green = '0;
	logic [7:0]  src_blue = '0;
	logic [7:0]  src_alpha = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_blue;
	logic [7:0]  out_green;
	logic [7:0]  out_red;
	logic [7:0]  out_alpha;
	logic        inside_res;
	logic        hit;

	// Canvas image and register copies, as the block should hold them
	sac_pkg::pixel_t   canvas_model [0:MAX_W*MAX_H-1];
	logic [8:0]        cur_cw = 9'd256;
	logic [8:0]        cur_ch = 9'd256;
	logic signed [9:0] cur_dx = '0;
	logic signed [9:0] cur_dy = '0;
	logic [8:0]        cur_fw = '0;
	logic [8:0]        cur_fh = '0;

	read_word_t expected_reads [$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	bit         send_gaps = 1'b1;
	bit         recv_gaps = 1'b1;

	sprite_alpha_compositor_core #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.src_red   (src_red),
		.src_green (src_green),
		.src_blue  (src_blue),
		.src_alpha (src_alpha),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_blue  (out_blue),
		.out_green (out_green),
		.out_red   (out_red),
		.out_alpha (out_alpha),
		.inside_res(inside_res),
		.hit       (hit)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Size in use, capped at the store's dimension
	function automatic int clip_dim(logic [8:0] v, int lim);
		return (int'(v) < lim) ? int'(v) : lim;
	endfunction

	function automatic bit on_canvas(int x, int y, int cols, int rows);
		return x >= 0 && y >= 0 && x < cols && y < rows;
	endfunction

	// One channel of src over dst, both divisions truncating
	function automatic logic [7:0] over_channel(logic [7:0] s, logic [7:0] a, logic [7:0] d);
		int full;
		full = int'(sac_pkg::FULL_ALPHA);
		return 8'((int'(s) * int'(a)) / full + (int'(d) * (full - int'(a))) / full);
	endfunction

	function automatic sprite_word_t make_word(logic [1:0] op, int x, int y,
			int r, int g, int b, int a);
		sprite_word_t w;
		w.op = op;
		w.x = 11'(x);
		w.y = 11'(y);
		w.red = 8'(r);
		w.green = 8'(g);
		w.blue = 8'(b);
		w.alpha = 8'(a);
		return w;
	endfunction

	// Update the canvas image for one accepted word; reads queue their answer
	task automatic composite_word(input sprite_word_t w);
		int              cols, rows, px, py, cx, cy;
		sac_pkg::pixel_t d, n;
		read_word_t      r;
		cols = clip_dim(cur_cw, MAX_W);
		rows = clip_dim(cur_ch, MAX_H);
		px = int'(w.x);
		py = int'(w.y);
		case (w.op)
			sac_pkg::KIND_CLEAR: begin
				for (int i = 0; i < cols * rows; i++)
					canvas_model[i] = '0;
			end
			sac_pkg::KIND_BLEND: begin
				cx = px + int'(cur_dx);
				cy = py + int'(cur_dy);
				if (px >= 0 && py >= 0 && px < int'(cur_fw) && py < int'(cur_fh)
						&& on_canvas(cx, cy, cols, rows) && w.alpha != 8'd0) begin
					d = canvas_model[cy * cols + cx];
					n.blue  = over_channel(w.blue, w.alpha, d.blue);
					n.green = over_channel(w.green, w.alpha, d.green);
					n.red   = over_channel(w.red, w.alpha, d.red);
					// a + d*(255-a)/255 is the same sum with a full source
					n.alpha = over_channel(sac_pkg::FULL_ALPHA, w.alpha, d.alpha);
					canvas_model[cy * cols + cx] = n;
				end
			end
			sac_pkg::KIND_READ: begin
				r = '0;
				if (on_canvas(px, py, cols, rows)) begin
					d = canvas_model[py * cols + px];
					r.blue = d.blue;
					r.green = d.green;
					r.red = d.red;
					r.alpha = d.alpha;
					r.in_canvas = 1'b1;
					r.hit = (d.alpha > sac_pkg::HIT_FLOOR);
				end
				expected_reads.insert(expected_reads.size(), r);
			end
			default: ;
		endcase
	endtask

	// Present one word and hold it until taken; valid stays up for a back-to-back word
	task automatic send_word(input sprite_word_t w);
		int gap;
		gap = send_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= w.op;
		pos_x <= w.x;
		pos_y <= w.y;
		src_red <= w.red;
		src_green <= w.green;
		src_blue <= w.blue;
		src_alpha <= w.alpha;
		do @(posedge clk); while (in_stall);
		composite_word(w);
	endtask

	// Drain: all read words back, blend pipeline empty, no clear walk running
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_reads.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic load_config(input int cw, input int ch, input int dx, input int dy,
			input int fw, input int fh);
		logic [2:0] reg_ids [6];
		logic [9:0] values [6];
		reg_ids = '{sac_pkg::REG_CANVAS_WIDTH, sac_pkg::REG_CANVAS_HEIGHT,
			sac_pkg::REG_DEST_X, sac_pkg::REG_DEST_Y,
			sac_pkg::REG_FRAME_WIDTH, sac_pkg::REG_FRAME_HEIGHT};
		values = '{10'(cw), 10'(ch), 10'(dx), 10'(dy), 10'(fw), 10'(fh)};
		wait_idle();
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_ids[i];
			cfg_data <= values[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_cw = 9'(cw);
		cur_ch = 9'(ch);
		cur_dx = 10'(dx);
		cur_dy = 10'(dy);
		cur_fw = 9'(fw);
		cur_fh = 9'(fh);
	endtask

	// Reset values: full 256x256 canvas, empty frame. The clear defines the whole store.
	task automatic test_reset_state();
		send_word(make_word(sac_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_READ, 255, 255, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_READ, 256, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_READ, -1024, 1023, 0, 0, 0, 0));
		// empty frame drops every blend
		send_word(make_word(sac_pkg::KIND_BLEND, 0, 0, 255, 255, 255, 255));
		send_word(make_word(KIND_UNUSED, 0, 0, 255, 255, 255, 255));
		send_word(make_word(sac_pkg::KIND_READ, 0, 0, 0, 0, 0, 0));
	endtask

	// Over operator, hit threshold, transparent and out-of-frame drops
	task automatic test_blend_over();
		load_config(8, 8, 0, 0, 8, 8);
		send_word(make_word(sac_pkg::KIND_BLEND, 0, 0, 255, 0, 128, 255));
		send_word(make_word(sac_pkg::KIND_READ, 0, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_BLEND, 0, 0, 0, 255, 255, 128));
		send_word(make_word(sac_pkg::KIND_READ, 0, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_BLEND, 1, 0, 200, 200, 200, 16));
		send_word(make_word(sac_pkg::KIND_BLEND, 2, 0, 200, 200, 200, 17));
		send_word(make_word(sac_pkg::KIND_READ, 1, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_READ, 2, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_BLEND, 3, 0, 255, 255, 255, 0));
		send_word(make_word(sac_pkg::KIND_READ, 3, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_BLEND, 8, 0, 255, 255, 255, 255));
		send_word(make_word(sac_pkg::KIND_BLEND, -1, 0, 255, 255, 255, 255));
		send_word(make_word(sac_pkg::KIND_READ, 7, 0, 0, 0, 0, 0));
	endtask

	// Negative destination column, clipping on the left, right and bottom canvas edges
	task automatic test_clip_offset();
		load_config(16, 12, -3, 5, 20, 10);
		send_word(make_word(sac_pkg::KIND_BLEND, 2, 0, 10, 20, 30, 255));
		send_word(make_word(sac_pkg::KIND_BLEND, 3, 0, 40, 50, 60, 200));
		send_word(make_word(sac_pkg::KIND_BLEND, 18, 6, 70, 80, 90, 255));
		send_word(make_word(sac_pkg::KIND_BLEND, 19, 6, 255, 255, 255, 255));
		send_word(make_word(sac_pkg::KIND_BLEND, 5, 7, 255, 255, 255, 255));
		send_word(make_word(sac_pkg::KIND_READ, 0, 5, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_READ, 15, 11, 0, 0, 0, 0));
	endtask

	// Register extremes, oversized and zero-sized canvas, single-pixel canvas
	task automatic test_config_extremes();
		load_config(256, 256, -512, -512, 256, 256);
		send_word(make_word(sac_pkg::KIND_BLEND, 255, 255, 255, 255, 255, 255));
		load_config(256, 256, 511, 511, 0, 0);
		send_word(make_word(sac_pkg::KIND_BLEND, 0, 0, 255, 255, 255, 255));
		load_config(511, 2, 0, 0, 256, 2);
		send_word(make_word(sac_pkg::KIND_BLEND, 255, 1, 1, 2, 3, 99));
		send_word(make_word(sac_pkg::KIND_READ, 255, 1, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_READ, 256, 1, 0, 0, 0, 0));
		load_config(0, 5, 0, 0, 4, 4);
		send_word(make_word(sac_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_BLEND, 0, 0, 255, 255, 255, 255));
		send_word(make_word(sac_pkg::KIND_READ, 0, 0, 0, 0, 0, 0));
		load_config(1, 1, 0, 0, 1, 1);
		send_word(make_word(sac_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_BLEND, 0, 0, 9, 8, 7, 200));
		send_word(make_word(sac_pkg::KIND_READ, 0, 0, 0, 0, 0, 0));
		send_word(make_word(sac_pkg::KIND_READ, 1, 0, 0, 0, 0, 0));
	endtask

	// Mostly in-frame blends and on-canvas reads, with stray positions, clears and noise
	function automatic sprite_word_t random_word(int cols, int rows, int fw, int fh);
		sprite_word_t w;
		int           pick;
		pick = $urandom_range(0, 99);
		w.op = sac_pkg::KIND_READ;
		w.x = 11'($urandom);
		w.y = 11'($urandom);
		w.red = 8'($urandom);
		w.green = 8'($urandom);
		w.blue = 8'($urandom);
		case ($urandom_range(0, 7))
			0: w.alpha = 8'd0;
			1: w.alpha = sac_pkg::FULL_ALPHA;
			2: w.alpha = sac_pkg::HIT_FLOOR + 8'($urandom_range(0, 1));
			default: w.alpha = 8'($urandom);
		endcase
		if (pick < 45) begin
			w.op = sac_pkg::KIND_BLEND;
			if (fw > 0)
				w.x = 11'($urandom_range(0, fw - 1));
			if (fh > 0)
				w.y = 11'($urandom_range(0, fh - 1));
		end else if (pick < 53) begin
			w.op = sac_pkg::KIND_BLEND;
		end else if (pick < 85) begin
			w.x = 11'($urandom_range(0, cols - 1));
			w.y = 11'($urandom_range(0, rows - 1));
		end else if (pick < 90) begin
			// just around the canvas border
			w.x = 11'(int'($urandom_range(0, cols + 3)) - 2);
			w.y = 11'(int'($urandom_range(0, rows + 3)) - 2);
		end else if (pick < 97) begin
			// long clear walks are kept for the directed part
			if (pick >= 94 && cols * rows <= 1024)
				w.op = sac_pkg::KIND_CLEAR;
		end else begin
			w.op = KIND_UNUSED;
		end
		return w;
	endfunction

	task automatic test_random_traffic();
		int cw, ch, dx, dy, fw, fh;
		for (int phase = 0; phase < 16; phase++) begin
			if ($urandom_range(0, 7) == 0) begin
				cw = $urandom_range(1, 256);
				ch = $urandom_range(1, 256);
			end else begin
				cw = $urandom_range(1, 20);
				ch = $urandom_range(1, 20);
			end
			if ($urandom_range(0, 3) == 0) begin
				dx = int'($urandom_range(0, 1023)) - 512;
				dy = int'($urandom_range(0, 1023)) - 512;
			end else begin
				dx = int'($urandom_range(0, 10)) - 5;
				dy = int'($urandom_range(0, 10)) - 5;
			end
			fw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (cw > 248) ? 256 : cw + 8);
			fh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (ch > 248) ? 256 : ch + 8);
			load_config(cw, ch, dx, dy, fw, fh);
			for (int n = 0; n < 104; n++) begin
				// switch idling on and off in stretches
				if (n % 26 == 0) begin
					send_gaps = ($urandom_range(0, 3) != 0);
					recv_gaps = ($urandom_range(0, 3) != 0);
				end
				send_word(random_word(cw, ch, fw, fh));
			end
		end
	endtask

	// Result side: random stall per word, compare against the oldest expectation
	initial begin : result_sink
		int         hold;
		read_word_t got;
		read_word_t want;
		do @(posedge clk); while (!arst_n);
		forever begin
			hold = recv_gaps ? $urandom_range(0, 6) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got = {out_blue, out_green, out_red, out_alpha, inside_res, hit};
			if (expected_reads.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: read word with none expected: %h", $time, got);
				mismatch_count++;
			end else begin
				want = expected_reads.pop_front();
				if (got.blue !== want.blue || got.green !== want.green
						|| got.red !== want.red || got.alpha !== want.alpha
						|| got.in_canvas !== want.in_canvas || got.hit !== want.hit) begin
					if (mismatch_count < 10)
						$display({"%0t: read word mismatch: expected b=%0d g=%0d r=%0d a=%0d ",
							"in=%b hit=%b, got b=%0d g=%0d r=%0d a=%0d in=%b hit=%b"},
							$time, want.blue, want.green, want.red, want.alpha,
							want.in_canvas, want.hit, got.blue, got.green, got.red,
							got.alpha, got.in_canvas, got.hit);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_blend_over();
		test_clip_offset();
		test_config_extremes();
		test_random_traffic();
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_reads.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
